FILE: rtl/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg
// types and codes shared by the huffman tree builder cells and top level
// ----------------------------------------------------------------------------
package htb_pkg;

  localparam int NODE_ID_W = 9;
  localparam int OUT_W_W   = 48;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  localparam logic [1:0] ST_MERGED   = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_MERGE  = 2'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  leaf_symbol;
    logic [39:0] leaf_weight;
  } htb_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [NODE_ID_W-1:0] new_node;
    logic [NODE_ID_W-1:0] first_child;
    logic [NODE_ID_W-1:0] second_child;
    logic [OUT_W_W-1:0]   node_weight;
    logic                 tree_done;
  } htb_out_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [NODE_ID_W-1:0] id;
  } htb_ctrl_t;

endpackage

FILE: rtl/htb_cell.sv
// ----------------------------------------------------------------------------
// htb_cell
// one slot of the sorted live node chain, ordered by weight then node id
// ----------------------------------------------------------------------------
module htb_cell import htb_pkg::*; #(
  parameter int WEIGHT_BITS = 48,
  parameter bit IS_HEAD     = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  htb_ctrl_t              ctrl_i,
  input  logic [WEIGHT_BITS-1:0] new_w_i,
  input  logic                   l_v_i,
  input  logic [WEIGHT_BITS-1:0] l_w_i,
  input  logic [NODE_ID_W-1:0]   l_id_i,
  input  logic                   l_lt_i,
  input  logic                   r1_v_i,
  input  logic [WEIGHT_BITS-1:0] r1_w_i,
  input  logic [NODE_ID_W-1:0]   r1_id_i,
  input  logic                   r1_lt_i,
  input  logic                   r2_v_i,
  input  logic [WEIGHT_BITS-1:0] r2_w_i,
  input  logic [NODE_ID_W-1:0]   r2_id_i,
  input  logic                   r2_lt_i,
  output logic                   v_o,
  output logic [WEIGHT_BITS-1:0] w_o,
  output logic [NODE_ID_W-1:0]   id_o,
  output logic                   lt_o
);

  logic                   v_q, v_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic [NODE_ID_W-1:0]   id_q, id_d;

  assign lt_o = v_q && (w_q <= new_w_i);

  always_comb begin
    v_d  = v_q;
    w_d  = w_q;
    id_d = id_q;
    case (ctrl_i.mode)
      CELL_INSERT: begin
        if (lt_o) begin
          v_d = v_q;
        end else if (IS_HEAD || l_lt_i) begin
          v_d  = 1'b1;
          w_d  = new_w_i;
          id_d = ctrl_i.id;
        end else begin
          v_d  = l_v_i;
          w_d  = l_w_i;
          id_d = l_id_i;
        end
      end
      CELL_MERGE: begin
        if (r2_lt_i) begin
          v_d  = r2_v_i;
          w_d  = r2_w_i;
          id_d = r2_id_i;
        end else if (IS_HEAD || r1_lt_i) begin
          v_d  = 1'b1;
          w_d  = new_w_i;
          id_d = ctrl_i.id;
        end else begin
          v_d  = r1_v_i;
          w_d  = r1_w_i;
          id_d = r1_id_i;
        end
      end
      default: begin
        v_d = v_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= w_d;
    id_q <= id_d;
  end

  assign v_o  = v_q;
  assign w_o  = w_q;
  assign id_o = id_q;

endmodule

FILE: rtl/huffman_tree_builder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_builder_top
// huffman tree construction over a sorted chain of node cells
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o / in_data_i, one item per transfer.
//   a load item inserts a leaf and gives no result; a load once MAX_LEAVES
//   node ids are in use gives a status record.
// a merge item takes the two head cells of the sorted chain (least weight,
//   lower id on ties), adds them, and inserts the new node while the chain
//   shifts; it gives one record on out_valid_o / out_stall_i / out_data_o.
// a load is written into the chain as it is accepted; a refused load, empty or
//   complete merge passes through S_EMIT to the output register, a merge
//   through S_MERGE and S_EMIT; the next item can be taken once the record
//   sits in the output register.
// when the receiver stalls, the record is held in the output register and
//   one more finished record waits inside; input then stalls.
// reset clears the valid bit of every cell, the counters and the output
//   valid at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_tree_builder_top import htb_pkg::*; #(
  parameter int MAX_LEAVES  = 256,
  parameter int WEIGHT_BITS = 48
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  htb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output htb_out_t out_data_o
);

  localparam int CNT_W = $clog2(MAX_LEAVES + 1);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MERGE = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

  logic [1:0]           state_q;
  logic [NODE_ID_W-1:0] node_count_q;
  logic [CNT_W-1:0]     live_count_q;
  logic                 out_valid_q;
  htb_out_t             out_q, res_q, res_d;
  logic [WEIGHT_BITS-1:0] sum_q, sum_d;

  logic                   cv  [MAX_LEAVES];
  logic                   clt [MAX_LEAVES];
  logic [WEIGHT_BITS-1:0] cw  [MAX_LEAVES];
  logic [NODE_ID_W-1:0]   cid [MAX_LEAVES];

  htb_ctrl_t              ctrl;
  logic [WEIGHT_BITS-1:0] new_w;
  logic                   in_acc, out_free, full;
  logic [WEIGHT_BITS+39:0] leaf_ext;
  logic [WEIGHT_BITS-1:0] leaf_sat;
  logic [WEIGHT_BITS:0]   sum_wide;
  logic [WEIGHT_BITS+OUT_W_W-1:0] sum_ext, head_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (node_count_q >= NODE_ID_W'(MAX_LEAVES));

  assign leaf_ext = {{WEIGHT_BITS{1'b0}}, in_data_i.leaf_weight};
  assign leaf_sat = (leaf_ext[WEIGHT_BITS+39:WEIGHT_BITS] != '0) ? WMAX
                  : leaf_ext[WEIGHT_BITS-1:0];

  assign sum_wide = {1'b0, cw[0]} + {1'b0, cw[1]};
  assign sum_d    = sum_wide[WEIGHT_BITS] ? WMAX : sum_wide[WEIGHT_BITS-1:0];
  assign sum_ext  = {{OUT_W_W{1'b0}}, sum_d};
  assign head_ext = {{OUT_W_W{1'b0}}, cw[0]};

  always_comb begin
    ctrl.id = node_count_q;
    if (state_q == S_MERGE) begin
      ctrl.mode = CELL_MERGE;
      new_w     = sum_q;
    end else if (in_acc && in_data_i.op == OP_LOAD && !full) begin
      ctrl.mode = CELL_INSERT;
      new_w     = leaf_sat;
    end else begin
      ctrl.mode = CELL_HOLD;
      new_w     = leaf_sat;
    end
  end

  always_comb begin
    res_d = '0;
    if (in_data_i.op == OP_LOAD) begin
      res_d.status = ST_FULL;
    end else if (live_count_q == '0) begin
      res_d.status = ST_EMPTY;
    end else if (live_count_q == CNT_W'(1)) begin
      res_d.status      = ST_COMPLETE;
      res_d.new_node    = cid[0];
      res_d.node_weight = head_ext[OUT_W_W-1:0];
      res_d.tree_done   = 1'b1;
    end else begin
      res_d.status       = ST_MERGED;
      res_d.new_node     = node_count_q;
      res_d.first_child  = cid[0];
      res_d.second_child = cid[1];
      res_d.node_weight  = sum_ext[OUT_W_W-1:0];
      res_d.tree_done    = (live_count_q == CNT_W'(2));
    end
  end

  for (genvar g = 0; g < MAX_LEAVES; g++) begin : g_cell
    logic                   l_v, l_lt, r1_v, r1_lt, r2_v, r2_lt;
    logic [WEIGHT_BITS-1:0] l_w, r1_w, r2_w;
    logic [NODE_ID_W-1:0]   l_id, r1_id, r2_id;

    if (g > 0) begin : g_l
      assign l_v  = cv[g-1];
      assign l_w  = cw[g-1];
      assign l_id = cid[g-1];
      assign l_lt = clt[g-1];
    end else begin : g_nl
      assign l_v  = 1'b0;
      assign l_w  = '0;
      assign l_id = '0;
      assign l_lt = 1'b1;
    end
    if (g + 1 < MAX_LEAVES) begin : g_r1
      assign r1_v  = cv[g+1];
      assign r1_w  = cw[g+1];
      assign r1_id = cid[g+1];
      assign r1_lt = clt[g+1];
    end else begin : g_nr1
      assign r1_v  = 1'b0;
      assign r1_w  = '0;
      assign r1_id = '0;
      assign r1_lt = 1'b0;
    end
    if (g + 2 < MAX_LEAVES) begin : g_r2
      assign r2_v  = cv[g+2];
      assign r2_w  = cw[g+2];
      assign r2_id = cid[g+2];
      assign r2_lt = clt[g+2];
    end else begin : g_nr2
      assign r2_v  = 1'b0;
      assign r2_w  = '0;
      assign r2_id = '0;
      assign r2_lt = 1'b0;
    end

    htb_cell #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .IS_HEAD     (g == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .new_w_i (new_w),
      .l_v_i   (l_v),
      .l_w_i   (l_w),
      .l_id_i  (l_id),
      .l_lt_i  (l_lt),
      .r1_v_i  (r1_v),
      .r1_w_i  (r1_w),
      .r1_id_i (r1_id),
      .r1_lt_i (r1_lt),
      .r2_v_i  (r2_v),
      .r2_w_i  (r2_w),
      .r2_id_i (r2_id),
      .r2_lt_i (r2_lt),
      .v_o     (cv[g]),
      .w_o     (cw[g]),
      .id_o    (cid[g]),
      .lt_o    (clt[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= '0;
      live_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.op == OP_LOAD) begin
              if (full) begin
                state_q <= S_EMIT;
              end else begin
                node_count_q <= node_count_q + 1'b1;
                live_count_q <= live_count_q + 1'b1;
              end
            end else if (live_count_q > CNT_W'(1)) begin
              state_q <= S_MERGE;
            end else begin
              state_q <= S_EMIT;
            end
          end
        end
        S_MERGE: begin
          node_count_q <= node_count_q + 1'b1;
          live_count_q <= live_count_q - 1'b1;
          state_q      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
      sum_q <= sum_d;
    end
    if (state_q == S_EMIT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_head_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_count_q == '0) == !cv[0])
    else $error("head cell valid disagrees with live count");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[1] |-> (cv[0] && cw[0] <= cw[1]))
    else $error("chain head out of order");

  a_merge_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> (live_count_q >= CNT_W'(2)))
    else $error("merge with fewer than two live nodes");

  a_id_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_count_q <= NODE_ID_W'(2 * MAX_LEAVES - 1))
    else $error("node id count beyond tree size");

endmodule
